### rtl/eka_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eka_pkg
// Types and constants shared by the escape key assembler.
// ----------------------------------------------------------------------------
package eka_pkg;

    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_POLL   = 2'd1;
    localparam logic [1:0] REQ_REPEAT = 2'd2;

    localparam logic [1:0] KIND_PLAIN   = 2'd0;
    localparam logic [1:0] KIND_CLOSED  = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_REPEAT  = 2'd3;

    localparam logic [7:0] KEY_ESC   = 8'h1B;
    localparam logic [7:0] KEY_TILDE = 8'h7E;
    localparam logic [7:0] KEY_A     = 8'h41;
    localparam logic [7:0] KEY_B     = 8'h42;
    localparam logic [7:0] KEY_C     = 8'h43;
    localparam logic [7:0] KEY_D     = 8'h44;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    typedef struct packed {
        logic        esc_open;
        logic [31:0] esc_deadline;
        logic [31:0] esc_code;
        logic        rpt_armed;
        logic [31:0] rpt_deadline;
        logic [31:0] rpt_key;
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  rx_byte;
        logic [31:0] now;
        logic [30:0] repeat_delay;
        logic [31:0] repeat_code;
    } t_item;

    typedef struct packed {
        logic        emit;
        logic [31:0] key_code;
        logic [1:0]  key_kind;
    } t_result;

    function automatic logic is_closer(input logic [7:0] b);
        return b inside {KEY_TILDE, KEY_A, KEY_B, KEY_C, KEY_D};
    endfunction

endpackage

### rtl/eka_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eka_step
// Next-state and result logic for one beat of the escape key assembler.
// ----------------------------------------------------------------------------
module eka_step (
    input  eka_pkg::t_state  i_state,
    input  eka_pkg::t_item   i_item,
    input  logic [15:0]      i_timeout,
    output eka_pkg::t_state  o_state,
    output eka_pkg::t_result o_result
);

    logic [31:0] shifted;
    logic        esc_expired;
    logic        rpt_expired;

    assign shifted     = {i_state.esc_code[23:0], i_item.rx_byte};
    assign esc_expired = i_state.esc_open && (i_item.now > i_state.esc_deadline);
    assign rpt_expired = i_state.rpt_armed && (i_item.now > i_state.rpt_deadline);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.req_type)
            eka_pkg::REQ_BYTE: begin
                if (i_state.esc_open) begin
                    o_state.esc_code = shifted;
                    if (eka_pkg::is_closer(i_item.rx_byte)) begin
                        o_state.esc_open  = 1'b0;
                        o_result.emit     = 1'b1;
                        o_result.key_code = shifted;
                        o_result.key_kind = eka_pkg::KIND_CLOSED;
                    end
                end else if (i_item.rx_byte == eka_pkg::KEY_ESC) begin
                    o_state.esc_open     = 1'b1;
                    o_state.esc_deadline = i_item.now + {16'd0, i_timeout};
                    o_state.esc_code     = {24'd0, i_item.rx_byte};
                end else begin
                    o_result.emit     = 1'b1;
                    o_result.key_code = {24'd0, i_item.rx_byte};
                    o_result.key_kind = eka_pkg::KIND_PLAIN;
                end
            end
            eka_pkg::REQ_POLL: begin
                if (esc_expired) begin
                    o_state.esc_open  = 1'b0;
                    o_result.emit     = 1'b1;
                    o_result.key_code = i_state.esc_code;
                    o_result.key_kind = eka_pkg::KIND_TIMEOUT;
                end else if (rpt_expired) begin
                    o_state.rpt_armed = 1'b0;
                    o_result.emit     = 1'b1;
                    o_result.key_code = i_state.rpt_key;
                    o_result.key_kind = eka_pkg::KIND_REPEAT;
                end
            end
            eka_pkg::REQ_REPEAT: begin
                o_state.rpt_armed    = 1'b1;
                o_state.rpt_deadline = i_item.now + {1'b0, i_item.repeat_delay};
                o_state.rpt_key      = i_item.repeat_code;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

### rtl/escape_key_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_key_assembler
// Turns terminal bytes, idle polls and repeat requests into key codes.
// ----------------------------------------------------------------------------
// One beat is taken every cycle unless the input register stalls. A beat is
// held in an input register, worked in one pass of compare, shift and 32-bit
// add logic against the sequence and repeat state, and any key lands in a
// result register. A held result stalls the input register only once both
// registers are full. The timeout register is written through the
// configuration channel, which is always ready.
module escape_key_assembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_now,
    input  logic [30:0] i_repeat_delay,
    input  logic [31:0] i_repeat_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_key_code,
    output logic [1:0]  o_key_kind,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic             r_in_valid;
    eka_pkg::t_item   r_item;
    eka_pkg::t_state  r_state;
    eka_pkg::t_state  n_state;
    eka_pkg::t_result n_result;
    logic             r_out_valid;
    logic [31:0]      r_key_code;
    logic [1:0]       r_key_kind;
    logic [15:0]      r_timeout;
    logic             advance;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_key_code  = r_key_code;
    assign o_key_kind  = r_key_kind;
    assign o_cfg_ready = 1'b1;

    eka_step u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .i_timeout(r_timeout),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= eka_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    // hold the beat until the step logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.req_type     <= i_req_type;
            r_item.rx_byte      <= i_rx_byte;
            r_item.now          <= i_now;
            r_item.repeat_delay <= i_repeat_delay;
            r_item.repeat_code  <= i_repeat_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // advance the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.emit) begin
            r_key_code <= n_result.key_code;
            r_key_kind <= n_result.key_kind;
        end
    end

endmodule
